FILE: hdl/wpc_pkg.sv
// Shared types and constants for the workspace point clamp.
// Command/status structs, state and opcode enums, field codes.
// No dependencies.
package wpc_pkg;

  localparam int LAYERS    = 64;
  localparam int MAX_VERTS = 64;
  localparam int LAYER_W   = $clog2(LAYERS);
  localparam int VERT_W    = $clog2(MAX_VERTS);
  localparam int ADDR_W    = LAYER_W + VERT_W;
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);
  localparam int DIV_W     = 64;
  localparam int STEP_W    = $clog2(DIV_W);

  localparam logic [2:0] REG_LAYER_OFFSET = 3'd0;

  typedef enum logic [1:0] {
    CMD_WRITE_VERTEX = 2'd0,
    CMD_SET_COUNT    = 2'd1,
    CMD_QUERY        = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_INSIDE     = 3'd0,
    ST_CLAMPED    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_RANGE      = 3'd3,
    ST_DEGENERATE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_POINT, OP_WR_VERT, OP_WR_CNT, OP_PREV, OP_IN_MUL, OP_IN_CMP,
    OP_NR_MUL, OP_NR_CMP, OP_DP_MUL, OP_FAR, OP_PROD_X, OP_PROD_Y, OP_DIV_INIT,
    OP_DIV_STEP, OP_FIN_X, OP_FIN_Y, OP_RES_RANGE, OP_RES_EMPTY, OP_RES_INSIDE,
    OP_RES_DEGEN, OP_RES_NEAR, OP_PUSH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LAYER, S_CNT, S_JRD, S_JLD, S_IRD, S_IMUL, S_ICMP, S_IEND,
    S_NRD, S_NMUL, S_NCMP, S_NEND, S_FAR, S_FCHK, S_DINIT, S_DIV, S_DFIN,
    S_PY, S_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [VERT_W-1:0] idx;
    logic              first;
  } dp_cmd_t;

  typedef struct packed {
    logic             layer_ok;
    logic [CNT_W-1:0] cnt;
    logic             in_poly;
    logic             have2;
    logic             far;
  } dp_stat_t;

endpackage

FILE: hdl/wpc_chan_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// No dependencies.
interface wpc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [5:0]         layer;
  logic [5:0]         vertex_index;
  logic [6:0]         vertex_count;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;

  modport source (output valid, command, layer, vertex_index, vertex_count,
                  vertex_x, vertex_y, point_x, point_y, point_z, input ready);
  modport sink (input valid, command, layer, vertex_index, vertex_count,
                vertex_x, vertex_y, point_x, point_y, point_z, output ready);
endinterface

interface wpc_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;

  modport source (output valid, status, out_x, out_y, input ready);
  modport sink (input valid, status, out_x, out_y, output ready);
endinterface

FILE: hdl/wpc_datapath.sv
// Datapath: vertex and count memories, crossing test, nearest search,
// projection with a restoring divider, result and output registers.
// Depends on wpc_pkg.
module wpc_datapath import wpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [15:0] layer_offset,
  input  logic [5:0]         layer,
  input  logic [5:0]         vertex_index,
  input  logic [6:0]         vertex_count,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  input  logic signed [23:0] point_z,
  output logic [2:0]         status,
  output logic signed [23:0] out_x,
  output logic signed [23:0] out_y
);

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    logic signed [23:0] r;
    if (v > 30'sd8388607) r = 24'sh7FFFFF;
    else if (v < -30'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // query point and layer
  logic signed [23:0]  tx, ty;
  logic [LAYER_W-1:0]  lay;
  logic                lay_ok;
  logic                z_neg;
  logic [23:0]         z_mag;
  logic [15:0]         z_rnd;
  logic signed [17:0]  zr, li;

  // round height half away from zero, subtract offset
  always_comb begin
    z_neg = point_z[23];
    z_mag = z_neg ? 24'(-point_z) : point_z;
    z_rnd = 16'((25'(z_mag) + 25'd128) >> 8);
    zr    = z_neg ? -$signed({2'b00, z_rnd}) : $signed({2'b00, z_rnd});
    li    = zr - 18'(layer_offset);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_POINT) begin
      tx     <= point_x;
      ty     <= point_y;
      lay    <= li[LAYER_W-1:0];
      lay_ok <= (li >= 18'sd0) && (li < 18'(LAYERS));
    end
  end

  // vertex memory, registered read
  logic [31:0] vmem [LAYERS*MAX_VERTS];
  logic [31:0] vq;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WR_VERT && int'(layer) < LAYERS && int'(vertex_index) < MAX_VERTS) begin
      vmem[{layer, vertex_index}] <= {vertex_x, vertex_y};
    end
    vq <= vmem[{lay, cmd.idx}];
  end

  // count memory with valid bits
  logic [CNT_W-1:0]  cmem [LAYERS];
  logic [LAYERS-1:0] cvld;
  logic [CNT_W-1:0]  cq;
  logic              cvq;
  logic [CNT_W-1:0]  cnt_sat;
  assign cnt_sat = (int'(vertex_count) > MAX_VERTS) ? CNT_W'(MAX_VERTS) : vertex_count;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WR_CNT && int'(layer) < LAYERS) begin
      cmem[layer] <= cnt_sat;
    end
    cq  <= cmem[lay];
    cvq <= cvld[lay];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= '0;
    end else if (cmd.op == OP_WR_CNT && int'(layer) < LAYERS) begin
      cvld[layer] <= 1'b1;
    end
  end

  // vertex operands
  logic signed [15:0] vq_x, vq_y, cur_x, cur_y, prev_x, prev_y;
  logic signed [23:0] vx256, vy256;
  assign vq_x  = vq[31:16];
  assign vq_y  = vq[15:0];
  assign vx256 = {vq_x, 8'h00};
  assign vy256 = {vq_y, 8'h00};

  // crossing test terms
  logic signed [16:0] dy, dx;
  logic signed [24:0] ex_t, ey_t;
  logic signed [41:0] lhs, rhs;
  logic               edge_cross, dy_pos, in_poly, crosses;
  assign dy   = 17'(prev_y) - 17'(vq_y);
  assign dx   = 17'(prev_x) - 17'(vq_x);
  assign ex_t = 25'(tx) - 25'(vx256);
  assign ey_t = 25'(ty) - 25'(vy256);
  assign crosses = dy_pos ? (lhs < rhs) : (lhs > rhs);

  // nearest search
  logic [48:0]        sqx, sqy;
  logic [49:0]        dsum, d1, d2;
  logic signed [15:0] p1x, p1y, p2x, p2y;
  logic               have2, cur_is_p1;
  assign dsum      = 50'(sqx) + 50'(sqy);
  assign cur_is_p1 = (cur_x == p1x) && (cur_y == p1y);

  // projection terms
  logic signed [16:0] pa, pb, n1, n2;
  logic signed [24:0] e1, e2;
  logic [33:0]        dpx, dpy;
  logic [34:0]        dp, den;
  logic signed [41:0] m1, m2;
  logic signed [43:0] num;
  logic signed [60:0] prod;
  logic               far;
  assign pa = 17'(p1x) - 17'(p2x);
  assign pb = 17'(p1y) - 17'(p2y);
  assign e1 = 25'(tx) - 25'(signed'({p1x, 8'h00}));
  assign e2 = 25'(ty) - 25'(signed'({p1y, 8'h00}));
  assign dp = 35'(dpx) + 35'(dpy);

  // divider
  logic              pneg;
  logic [60:0]       pmag;
  logic [DIV_W-1:0]  dv;
  logic [35:0]       dsr, rem;
  logic [36:0]       trial;
  logic              ge;
  logic signed [28:0] qs;
  logic signed [29:0] ores;
  assign pmag  = prod[60] ? 61'(-prod) : 61'(prod);
  assign trial = {rem, dv[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign qs    = pneg ? -$signed({1'b0, dv[27:0]}) : $signed({1'b0, dv[27:0]});

  // result staging
  logic [2:0]         res_status;
  logic signed [23:0] res_x, res_y;

  always_comb begin
    ores = (cmd.op == OP_FIN_X) ? (30'(tx) - 30'(qs)) : (30'(ty) - 30'(qs));
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PREV: begin
        prev_x  <= vq_x;
        prev_y  <= vq_y;
        in_poly <= 1'b0;
      end
      OP_IN_MUL: begin
        cur_x      <= vq_x;
        cur_y      <= vq_y;
        lhs        <= ex_t * dy;
        rhs        <= dx * ey_t;
        edge_cross <= (vy256 > ty) != ($signed({prev_y, 8'h00}) > ty);
        dy_pos     <= dy > 17'sd0;
      end
      OP_IN_CMP: begin
        if (edge_cross && crosses) in_poly <= ~in_poly;
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      OP_NR_MUL: begin
        cur_x <= vq_x;
        cur_y <= vq_y;
        sqx   <= 49'(ex_t * ex_t);
        sqy   <= 49'(ey_t * ey_t);
      end
      OP_NR_CMP: begin
        // earliest vertex wins ties; second must differ from nearest
        if (cmd.first) begin
          d1 <= dsum; p1x <= cur_x; p1y <= cur_y; have2 <= 1'b0;
        end else if (dsum < d1) begin
          have2 <= 1'b1; d2 <= d1; p2x <= p1x; p2y <= p1y;
          d1 <= dsum; p1x <= cur_x; p1y <= cur_y;
        end else if ((!have2 || dsum < d2) && !cur_is_p1) begin
          have2 <= 1'b1; d2 <= dsum; p2x <= cur_x; p2y <= cur_y;
        end
      end
      OP_DP_MUL: begin
        dpx <= 34'(pa * pa);
        dpy <= 34'(pb * pb);
        n1  <= -pb;
        n2  <= pa;
        m1  <= e1 * (-pb);
        m2  <= e2 * pa;
      end
      OP_FAR: begin
        far <= 51'(d2) > {dp, 16'h0000};
        den <= dp;
        num <= 44'(m1) + 44'(m2);
      end
      OP_PROD_X: prod <= num * n1;
      OP_PROD_Y: prod <= num * n2;
      OP_DIV_INIT: begin
        pneg <= prod[60];
        dv   <= DIV_W'({pmag, 1'b0}) + DIV_W'(den);
        dsr  <= {den, 1'b0};
        rem  <= '0;
      end
      OP_DIV_STEP: begin
        rem <= ge ? 36'(trial - {1'b0, dsr}) : trial[35:0];
        dv  <= {dv[DIV_W-2:0], ge};
      end
      OP_FIN_X: res_x <= sat24(ores);
      OP_FIN_Y: begin
        res_y      <= sat24(ores);
        res_status <= ST_CLAMPED;
      end
      OP_RES_RANGE: begin
        res_status <= ST_RANGE; res_x <= '0; res_y <= '0;
      end
      OP_RES_EMPTY: begin
        res_status <= ST_EMPTY; res_x <= '0; res_y <= '0;
      end
      OP_RES_INSIDE: begin
        res_status <= ST_INSIDE; res_x <= tx; res_y <= ty;
      end
      OP_RES_DEGEN: begin
        res_status <= ST_DEGENERATE; res_x <= {p1x, 8'h00}; res_y <= {p1y, 8'h00};
      end
      OP_RES_NEAR: begin
        res_status <= ST_CLAMPED; res_x <= {p1x, 8'h00}; res_y <= {p1y, 8'h00};
      end
      OP_PUSH: begin
        status <= res_status;
        out_x  <= res_x;
        out_y  <= res_y;
      end
      default: ;
    endcase
  end

  assign stat.layer_ok = lay_ok;
  assign stat.cnt      = cvq ? cq : '0;
  assign stat.in_poly  = in_poly;
  assign stat.have2    = have2;
  assign stat.far      = far;

endmodule

FILE: hdl/wpc_ctrl.sv
// Controller: sequences writes and queries over the datapath.
// Depends on wpc_pkg.
module wpc_ctrl import wpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  state_t            state, state_next;
  logic [VERT_W-1:0] idx, idx_next;
  logic [STEP_W-1:0] step, step_next;
  logic              axis, axis_next;
  logic              out_full, out_full_next;
  logic              last;

  assign last = (idx == VERT_W'(stat.cnt - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
    idx  <= idx_next;
    step <= step_next;
    axis <= axis_next;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    axis_next  = axis;
    cmd.op     = OP_NONE;
    cmd.idx    = idx;
    cmd.first  = (idx == '0);
    in_ready   = 1'b0;
    out_full_next = out_full && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            CMD_WRITE_VERTEX: cmd.op = OP_WR_VERT;
            CMD_SET_COUNT:    cmd.op = OP_WR_CNT;
            CMD_QUERY: begin
              cmd.op     = OP_LOAD_POINT;
              state_next = S_LAYER;
            end
            default: ;
          endcase
        end
      end
      S_LAYER: begin
        if (!stat.layer_ok) begin
          cmd.op     = OP_RES_RANGE;
          state_next = S_OUT;
        end else begin
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        if (stat.cnt == '0) begin
          cmd.op     = OP_RES_EMPTY;
          state_next = S_OUT;
        end else begin
          idx_next   = VERT_W'(stat.cnt - CNT_W'(1));
          state_next = S_JRD;
        end
      end
      S_JRD: state_next = S_JLD;
      S_JLD: begin
        cmd.op     = OP_PREV;
        idx_next   = '0;
        state_next = S_IRD;
      end
      S_IRD: state_next = S_IMUL;
      S_IMUL: begin
        cmd.op     = OP_IN_MUL;
        state_next = S_ICMP;
      end
      S_ICMP: begin
        cmd.op = OP_IN_CMP;
        if (last) begin
          state_next = S_IEND;
        end else begin
          idx_next   = idx + VERT_W'(1);
          state_next = S_IRD;
        end
      end
      S_IEND: begin
        if (stat.in_poly) begin
          cmd.op     = OP_RES_INSIDE;
          state_next = S_OUT;
        end else begin
          idx_next   = '0;
          state_next = S_NRD;
        end
      end
      S_NRD: state_next = S_NMUL;
      S_NMUL: begin
        cmd.op     = OP_NR_MUL;
        state_next = S_NCMP;
      end
      S_NCMP: begin
        cmd.op = OP_NR_CMP;
        if (last) begin
          state_next = S_NEND;
        end else begin
          idx_next   = idx + VERT_W'(1);
          state_next = S_NRD;
        end
      end
      S_NEND: begin
        if (!stat.have2) begin
          cmd.op     = OP_RES_DEGEN;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_DP_MUL;
          state_next = S_FAR;
        end
      end
      S_FAR: begin
        cmd.op     = OP_FAR;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        if (stat.far) begin
          cmd.op     = OP_RES_NEAR;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_PROD_X;
          axis_next  = 1'b0;
          state_next = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.op     = OP_DIV_INIT;
        step_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV_STEP;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) state_next = S_DFIN;
      end
      S_DFIN: begin
        if (!axis) begin
          cmd.op     = OP_FIN_X;
          state_next = S_PY;
        end else begin
          cmd.op     = OP_FIN_Y;
          state_next = S_OUT;
        end
      end
      S_PY: begin
        cmd.op     = OP_PROD_Y;
        axis_next  = 1'b1;
        state_next = S_DINIT;
      end
      S_OUT: begin
        // load the output register once it is free
        if (!out_full || out_ready) begin
          cmd.op        = OP_PUSH;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = out_full;

endmodule

FILE: hdl/workspace_point_clamp_top.sv
// Top level of the workspace point clamp: APB register, controller, datapath.
// Depends on wpc_pkg, wpc_chan_if, wpc_ctrl, wpc_datapath.
//
// Usage: requests arrive on req (valid/ready). Command write-vertex stores
// one vertex, set-count stores a layer's vertex count; both are written at
// the accepting edge and give no result. A query gives one result on rsp
// (status, out_x, out_y). A query makes one vertex memory read per vertex
// in each of its walks (crossing test, then nearest search, skipped when the
// point is inside), and a projection adds two 64-step restoring divisions.
// One request is worked on at a time; ready is high only while the
// controller is idle.
// Results wait in an output register, so a new request is accepted while a
// result is held by a stalled receiver; a finished query waits until that
// register is free. Reset clears the layer counts (all layers empty), the
// layer offset and the handshake state; vertex storage is not cleared.
// layer_offset sits at APB address 0 and should be written only when idle.
module workspace_point_clamp_top import wpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wpc_req_if.sink     req,
  wpc_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [15:0] layer_offset;
  logic [2:0]         rsp_status;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_offset <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LAYER_OFFSET[2]) begin
      layer_offset <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_LAYER_OFFSET[2]) ? 32'(layer_offset) : '0;

  wpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  wpc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .layer_offset (layer_offset),
    .layer        (req.layer),
    .vertex_index (req.vertex_index),
    .vertex_count (req.vertex_count),
    .vertex_x     (req.vertex_x),
    .vertex_y     (req.vertex_y),
    .point_x      (req.point_x),
    .point_y      (req.point_y),
    .point_z      (req.point_z),
    .status       (rsp_status),
    .out_x        (rsp.out_x),
    .out_y        (rsp.out_y)
  );
  assign rsp.status = rsp_status;

  // a query keeps the block busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.command == CMD_QUERY |=> !req.ready)
    else $error("request taken right after a query");

  // empty and out-of-range results carry a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_EMPTY || rsp.status == ST_RANGE)
      |-> rsp.out_x == '0 && rsp.out_y == '0)
    else $error("nonzero point on empty or out-of-range result");

  // status code stays within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status <= ST_DEGENERATE)
    else $error("undefined status code");

endmodule
